>>> hdl/boxov_pkg.sv
`default_nettype none
package boxov_pkg;

  localparam int unsigned CFG_W = 7;
  localparam int unsigned IDX_W = 6;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

endpackage
`default_nettype wire

>>> hdl/box_obstacle_overlap_check.sv
`default_nettype none
// write transaction: block stays idle, no result
// query transaction: busy while k entries are compared (k at most active_obstacles),
//   result strobe registered after the last compare, next start taken in the strobe cycle
// query with zero active obstacles: no busy cycle, safe strobe in the next cycle
// one table entry read per cycle from the two-port box memory; the receiver cannot stall
// rst_n synchronous: clears the active count and control state, box memory left undefined
module box_obstacle_overlap_check #(
  parameter int unsigned MAX_OBSTACLES = 64,
  parameter int unsigned COORD_WIDTH   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 in_command,
  input  wire logic [boxov_pkg::IDX_W-1:0]          in_entry_index,
  input  wire logic signed [COORD_WIDTH-1:0]        in_x_min,
  input  wire logic signed [COORD_WIDTH-1:0]        in_x_max,
  input  wire logic signed [COORD_WIDTH-1:0]        in_y_min,
  input  wire logic signed [COORD_WIDTH-1:0]        in_y_max,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [boxov_pkg::CFG_W-1:0]          cfg_active_obstacles,
  output logic                                      out_valid,
  output logic                                      out_safe
);

  localparam int unsigned AW    = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned ENT_W = 4 * COORD_WIDTH;

  boxov_pkg::state_t state_r, state_nxt;
  logic [boxov_pkg::CFG_W-1:0] active_r;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic [CNT_W-1:0] cmp_r, cmp_nxt;
  logic             pend_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_safe_r, out_safe_nxt;
  logic             ld_rect;

  logic signed [COORD_WIDTH-1:0] qx_min_r, qx_max_r, qy_min_r, qy_max_r;

  logic [31:0]      lim_ext;
  logic [31:0]      slot_ext;
  logic [31:0]      iss_ext;
  logic [31:0]      cfg_ext;
  logic             rd_en;
  logic             wr_en;
  logic [ENT_W-1:0] rd_data;
  logic             pair_safe;
  logic             last_cmp;

  logic signed [COORD_WIDTH-1:0] bx_min, bx_max, by_min, by_max;

  assign lim_ext  = 32'(active_r);
  assign slot_ext = 32'(in_entry_index);
  assign iss_ext  = 32'(iss_r);
  assign cfg_ext  = 32'(cfg_active_obstacles);

  assign busy      = (state_r != boxov_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_safe  = out_safe_r;

  assign wr_en = (state_r == boxov_pkg::ST_IDLE) && start &&
                 (in_command == boxov_pkg::CMD_WRITE) && (slot_ext < MAX_OBSTACLES);
  assign rd_en = (state_r == boxov_pkg::ST_RUN) && (iss_ext < lim_ext);

  boxov_ram #(
    .WIDTH(ENT_W),
    .DEPTH(MAX_OBSTACLES)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(slot_ext[AW-1:0]),
    .wdata({in_x_min, in_x_max, in_y_min, in_y_max}),
    .re   (rd_en),
    .raddr(iss_ext[AW-1:0]),
    .rdata(rd_data)
  );

  assign bx_min = $signed(rd_data[4*COORD_WIDTH-1:3*COORD_WIDTH]);
  assign bx_max = $signed(rd_data[3*COORD_WIDTH-1:2*COORD_WIDTH]);
  assign by_min = $signed(rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign by_max = $signed(rd_data[COORD_WIDTH-1:0]);

  // edges or corners touching count as no overlap
  assign pair_safe = (qx_min_r >= bx_max) || (bx_min >= qx_max_r) ||
                     (qy_max_r <= by_min) || (by_max <= qy_min_r);
  assign last_cmp  = ((32'(cmp_r) + 32'd1) == lim_ext);

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = iss_r;
    cmp_nxt       = cmp_r;
    out_valid_nxt = 1'b0;
    out_safe_nxt  = out_safe_r;
    ld_rect       = 1'b0;
    unique case (state_r)
      boxov_pkg::ST_IDLE: begin
        if (start && (in_command == boxov_pkg::CMD_QUERY)) begin
          ld_rect = 1'b1;
          iss_nxt = '0;
          cmp_nxt = '0;
          if (active_r == '0) begin
            out_valid_nxt = 1'b1;
            out_safe_nxt  = 1'b1;
          end else begin
            state_nxt = boxov_pkg::ST_RUN;
          end
        end
      end
      boxov_pkg::ST_RUN: begin
        if (rd_en) begin
          iss_nxt = CNT_W'(iss_r + 1'b1);
        end
        if (pend_r) begin
          cmp_nxt = CNT_W'(cmp_r + 1'b1);
          if (!pair_safe) begin
            out_valid_nxt = 1'b1;
            out_safe_nxt  = 1'b0;
            state_nxt     = boxov_pkg::ST_IDLE;
          end else if (last_cmp) begin
            out_valid_nxt = 1'b1;
            out_safe_nxt  = 1'b1;
            state_nxt     = boxov_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = boxov_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= boxov_pkg::ST_IDLE;
      active_r    <= '0;
      iss_r       <= '0;
      cmp_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_safe_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      cmp_r       <= cmp_nxt;
      pend_r      <= rd_en;
      out_valid_r <= out_valid_nxt;
      out_safe_r  <= out_safe_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_ext > MAX_OBSTACLES) begin
          active_r <= boxov_pkg::CFG_W'(MAX_OBSTACLES);
        end else begin
          active_r <= cfg_active_obstacles;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_rect) begin
      qx_min_r <= in_x_min;
      qx_max_r <= in_x_max;
      qy_min_r <= in_y_min;
      qy_max_r <= in_y_max;
    end
  end

  a_no_write_during_walk: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("table write during query walk");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == boxov_pkg::ST_RUN && pend_r) |-> (32'(cmp_r) < lim_ext))
    else $error("compare index beyond active count");

  a_iss_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == boxov_pkg::ST_RUN) |-> (iss_ext <= lim_ext))
    else $error("read index beyond active count");

  a_query_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && start && in_command == boxov_pkg::CMD_QUERY && active_r != '0) |=> busy)
    else $error("query with active obstacles did not start a walk");

  a_empty_query_safe: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && start && in_command == boxov_pkg::CMD_QUERY && active_r == '0)
      |=> (out_valid && out_safe))
    else $error("empty table query not answered safe");

endmodule
`default_nettype wire

>>> hdl/boxov_ram.sv
`default_nettype none
module boxov_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                  wdata,
  input  wire logic                              re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
